/* hdl/tst_pkg.sv */
// Shared types and constants of the tick task scheduler table.
package tst_pkg;

    // Field widths fixed by the stream payloads.
    localparam int ACT_W      = 3;
    localparam int POS_W      = 5;
    localparam int ID_W       = 8;
    localparam int IN_DELAY_W = 16;
    localparam int OCC_W      = 5;
    localparam int LIMIT_W    = 5;

    // Input tdata layout, lowest bit first.
    localparam int S_TDATA_W   = 56;
    localparam int IN_ACT_LSB  = 0;
    localparam int IN_POS_LSB  = IN_ACT_LSB + ACT_W;
    localparam int IN_ID_LSB   = IN_POS_LSB + POS_W;
    localparam int IN_DLY_LSB  = IN_ID_LSB + ID_W;
    localparam int IN_PER_LSB  = IN_DLY_LSB + IN_DELAY_W;
    localparam int IN_REP_LSB  = IN_PER_LSB + IN_DELAY_W;

    // Output tdata layout, lowest bit first.
    localparam int M_TDATA_W   = 16;
    localparam int OUT_ID_LSB  = 0;
    localparam int OUT_ST_LSB  = OUT_ID_LSB + ID_W;
    localparam int OUT_OCC_LSB = OUT_ST_LSB + 1;

    // Reset value of the table limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Result kinds carried on tuser.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Action codes; the two unused codes are handled by default arms.
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND   = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_POP      = 3'd3,
        ACT_TICK     = 3'd4,
        ACT_DISPATCH = 3'd5
    } action_t;

    // Decision flags of the entry update unit.
    typedef struct packed {
        logic keep;   // write the entry back to the table
        logic run;    // report the entry as dispatched
    } unit_flags_t;

endpackage

/* hdl/tick_task_scheduler_table_top.sv */
// Tick task scheduler table: sequencer, task table RAM and run id buffer.
// Append, pop and failed actions go from accept straight to the status item;
// tick and dispatch walk every entry, insert and delete the entries that move,
// one entry per cycle through the shared update unit. Dispatch then emits a
// run notice per dispatched task before the status item; output stalls hold them.
// Reset (aresetn low, synchronous) empties the table and sets the limit to 16.
module tick_task_scheduler_table_top #(
    parameter int MAX_TASKS  = 16,
    parameter int DELAY_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // action, position, new_id, new_delay, new_period, new_repeat
    input  logic [tst_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // run_id, status, occupancy
    output logic [tst_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [tst_pkg::LIMIT_W-1:0]     cfg_wr_data
);

    import tst_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [DELAY_BITS-1:0] delay;
        logic [DELAY_BITS-1:0] period;
        logic                  rep;
        logic                  ready;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EREAD,
        ST_EOUT,
        ST_STAT
    } state_t;

    state_t                state_reg, state_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [CW-1:0]         count_reg, count_next;
    action_t               op_reg, op_next;
    logic                  fail_reg, fail_next;
    logic [IW-1:0]         pos_reg, pos_next;
    entry_t                new_reg, new_next;
    logic [IW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic                  vld_reg, vld_next;
    logic                  dec_reg, dec_next;
    logic [CW-1:0]         nrun_reg, nrun_next;
    logic [CW-1:0]         eptr_reg, eptr_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_kind_reg, m_kind_next;
    logic [ID_W-1:0]       m_id_reg, m_id_next;
    logic                  m_status_reg, m_status_next;
    logic [OCC_W-1:0]      m_occ_reg, m_occ_next;
    logic                  m_last_reg, m_last_next;

    // Table and run buffer ports.
    logic                  tbl_wr_en, tbl_rd_en;
    logic [IW-1:0]         tbl_wr_addr;
    entry_t                tbl_wr_data, tbl_rd_data;
    logic                  buf_wr_en, buf_rd_en;
    logic [ID_W-1:0]       buf_rd_data;

    // Update unit results.
    logic [DELAY_BITS-1:0] u_delay;
    logic                  u_ready;
    unit_flags_t           u_flags;

    // Decoded input fields and bounds.
    action_t               in_act;
    logic [XW-1:0]         in_pos, cnt_x, lim_x, ins_pos;
    logic                  out_free;

    assign in_act = action_t'(s_tdata[IN_ACT_LSB +: ACT_W]);
    assign in_pos = XW'(s_tdata[IN_POS_LSB +: POS_W]);
    assign cnt_x  = XW'(count_reg);
    assign lim_x  = (XW'(limit_reg) > XW'(MAX_TASKS)) ? XW'(MAX_TASKS) : XW'(limit_reg);
    assign ins_pos = (in_pos > cnt_x) ? cnt_x : in_pos;
    assign out_free = !m_valid_reg || m_tready;

    tst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_tbl (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (tbl_rd_data)
    );

    tst_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_runbuf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (nrun_reg[IW-1:0]),
        .wr_data (tbl_rd_data.id),
        .rd_en   (buf_rd_en),
        .rd_addr (eptr_reg[IW-1:0]),
        .rd_data (buf_rd_data)
    );

    tst_unit #(
        .DELAY_BITS (DELAY_BITS)
    ) u_unit (
        .op        (op_reg),
        .delay_in  (tbl_rd_data.delay),
        .period_in (tbl_rd_data.period),
        .rep_in    (tbl_rd_data.rep),
        .ready_in  (tbl_rd_data.ready),
        .delay_out (u_delay),
        .ready_out (u_ready),
        .flags     (u_flags)
    );

    // Sequencer: decode on accept, walk the table, then emit results.
    always_comb begin
        state_next    = state_reg;
        limit_next    = cfg_wr_en ? cfg_wr_data : limit_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        fail_next     = fail_reg;
        pos_next      = pos_reg;
        new_next      = new_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        rem_next      = rem_reg;
        vld_next      = 1'b0;
        dec_next      = dec_reg;
        nrun_next     = nrun_reg;
        eptr_next     = eptr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_id_next     = m_id_reg;
        m_status_next = m_status_reg;
        m_occ_next    = m_occ_reg;
        m_last_next   = m_last_reg;
        tbl_wr_en     = 1'b0;
        tbl_wr_addr   = wr_ptr_reg[IW-1:0];
        tbl_wr_data   = tbl_rd_data;
        tbl_rd_en     = 1'b0;
        buf_wr_en     = 1'b0;
        buf_rd_en     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next      = in_act;
                    fail_next    = STATUS_OK;
                    nrun_next    = '0;
                    new_next.id     = s_tdata[IN_ID_LSB +: ID_W];
                    new_next.delay  = DELAY_BITS'(s_tdata[IN_DLY_LSB +: IN_DELAY_W]);
                    new_next.period = DELAY_BITS'(s_tdata[IN_PER_LSB +: IN_DELAY_W]);
                    new_next.rep    = s_tdata[IN_REP_LSB];
                    new_next.ready  = 1'b0;
                    state_next   = ST_STAT;
                    case (in_act)
                        ACT_APPEND: begin
                            if (cnt_x >= lim_x) begin
                                fail_next = STATUS_FAIL;
                            end else begin
                                tbl_wr_en   = 1'b1;
                                tbl_wr_addr = count_reg[IW-1:0];
                                tbl_wr_data = new_next;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        ACT_INSERT: begin
                            if (in_pos > lim_x || cnt_x >= lim_x) begin
                                fail_next = STATUS_FAIL;
                            end else begin
                                pos_next    = IW'(ins_pos);
                                rd_ptr_next = IW'(count_reg - CW'(1));
                                wr_ptr_next = count_reg;
                                rem_next    = CW'(cnt_x - ins_pos);
                                dec_next    = 1'b1;
                                state_next  = ST_WALK;
                            end
                        end
                        ACT_DELETE: begin
                            if (in_pos == '0 || in_pos > lim_x || in_pos > cnt_x) begin
                                fail_next = STATUS_FAIL;
                            end else begin
                                rd_ptr_next = IW'(in_pos);
                                wr_ptr_next = CW'(in_pos - XW'(1));
                                rem_next    = CW'(cnt_x - in_pos);
                                dec_next    = 1'b0;
                                state_next  = ST_WALK;
                            end
                        end
                        ACT_POP: begin
                            if (count_reg == '0) begin
                                fail_next = STATUS_FAIL;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ACT_TICK, ACT_DISPATCH: begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            rem_next    = count_reg;
                            dec_next    = 1'b0;
                            state_next  = ST_WALK;
                        end
                        default: begin
                            fail_next = STATUS_FAIL;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                // Issue the next read.
                if (rem_reg != '0) begin
                    tbl_rd_en   = 1'b1;
                    rd_ptr_next = dec_reg ? rd_ptr_reg - IW'(1) : rd_ptr_reg + IW'(1);
                    rem_next    = rem_reg - CW'(1);
                    vld_next    = 1'b1;
                end
                // Process the entry read in the previous cycle.
                if (vld_reg) begin
                    tbl_wr_data.delay = u_delay;
                    tbl_wr_data.ready = u_ready;
                    if (u_flags.keep) begin
                        tbl_wr_en   = 1'b1;
                        wr_ptr_next = dec_reg ? wr_ptr_reg - CW'(1) : wr_ptr_reg + CW'(1);
                    end
                    if (u_flags.run) begin
                        buf_wr_en = 1'b1;
                        nrun_next = nrun_reg + CW'(1);
                    end
                end else if (rem_reg == '0) begin
                    // Walk finished: settle the count.
                    case (op_reg)
                        ACT_INSERT: begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_addr = pos_reg;
                            tbl_wr_data = new_reg;
                            count_next  = count_reg + CW'(1);
                        end
                        ACT_DELETE: begin
                            count_next = count_reg - CW'(1);
                        end
                        ACT_DISPATCH: begin
                            count_next = wr_ptr_reg;
                        end
                        default: begin
                            count_next = count_reg;
                        end
                    endcase
                    eptr_next  = '0;
                    state_next = (nrun_reg != '0) ? ST_EREAD : ST_STAT;
                end
            end

            ST_EREAD: begin
                buf_rd_en  = 1'b1;
                state_next = ST_EOUT;
            end

            ST_EOUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_RUN;
                    m_id_next     = buf_rd_data;
                    m_status_next = STATUS_OK;
                    m_occ_next    = OCC_W'(count_reg);
                    m_last_next   = 1'b0;
                    eptr_next     = eptr_reg + CW'(1);
                    state_next    = (eptr_reg + CW'(1) == nrun_reg) ? ST_STAT : ST_EREAD;
                end
            end

            ST_STAT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_STATUS;
                    m_id_next     = '0;
                    m_status_next = fail_reg;
                    m_occ_next    = OCC_W'(count_reg);
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_RESET;
            count_reg   <= '0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            count_reg   <= count_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        fail_reg     <= fail_next;
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        rem_reg      <= rem_next;
        dec_reg      <= dec_next;
        nrun_reg     <= nrun_next;
        eptr_reg     <= eptr_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_status_reg <= m_status_next;
        m_occ_reg    <= m_occ_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_occ_reg, m_status_reg, m_id_reg});

endmodule

/* hdl/tst_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/tst_unit.sv */
// Entry update unit shared by every step of a table walk.
module tst_unit #(
    parameter int DELAY_BITS = 16
) (
    input  tst_pkg::action_t       op,
    input  logic [DELAY_BITS-1:0]  delay_in,
    input  logic [DELAY_BITS-1:0]  period_in,
    input  logic                   rep_in,
    input  logic                   ready_in,
    output logic [DELAY_BITS-1:0]  delay_out,
    output logic                   ready_out,
    output tst_pkg::unit_flags_t   flags
);

    import tst_pkg::*;

    // Tick counts down or fires; dispatch reports ready tasks and drops
    // one-shot ones; shifts pass the entry through unchanged.
    always_comb begin
        delay_out  = delay_in;
        ready_out  = ready_in;
        flags.keep = 1'b1;
        flags.run  = 1'b0;
        case (op)
            ACT_TICK: begin
                if (delay_in == '0) begin
                    ready_out = 1'b1;
                    if (rep_in) begin
                        delay_out = period_in;
                    end
                end else begin
                    delay_out = delay_in - DELAY_BITS'(1);
                end
            end
            ACT_DISPATCH: begin
                if (ready_in) begin
                    flags.run  = 1'b1;
                    ready_out  = 1'b0;
                    flags.keep = rep_in;
                end
            end
            default: begin
                delay_out = delay_in;
            end
        endcase
    end

endmodule

/* hdl/tst_checker.sv */
// Port-level assertions for the tick task scheduler table, bound to the top level.
module tst_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic [tst_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    import tst_pkg::*;

    // A stalled result item holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    // Only the status item closes an action.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("tlast does not match item kind");

    // Run notices always report success.
    a_run_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_RUN |-> m_tdata[OUT_ST_LSB] == STATUS_OK)
        else $error("run notice carries a failure");

    // Status items carry no task id.
    a_stat_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tdata[OUT_ID_LSB +: ID_W] == '0)
        else $error("status item carries a task id");

    // Reset leaves the block idle with no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind tick_task_scheduler_table_top tst_checker u_tst_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the tick task scheduler table.
`timescale 1ns / 100ps

module tb;
    import tst_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_WAIT    = 19;

    // Action codes that the block has no arm for.
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    // One input item, unpacked.
    typedef struct packed {
        logic                  rep;
        logic [IN_DELAY_W-1:0] period;
        logic [IN_DELAY_W-1:0] delay;
        logic [ID_W-1:0]       id;
        logic [POS_W-1:0]      pos;
        logic [ACT_W-1:0]      act;
    } action_item_t;

    // One result item, unpacked.
    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  run_id;
        logic             status;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } report_t;

    // One table entry as the block should hold it.
    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [IN_DELAY_W-1:0] delay;
        logic [IN_DELAY_W-1:0] period;
        logic                  rep;
        logic                  ready;
    } task_entry_t;

    // Scoreboard: shadows the task table and queues the reports each action causes.
    class sched_scoreboard;
        task_entry_t        slots[TABLE_DEPTH];
        int unsigned        count = 0;
        logic [LIMIT_W-1:0] limit = LIMIT_RESET;
        report_t            due_reports[$];
        int unsigned        errors = 0;

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction

        function int unsigned task_count();
            return count;
        endfunction

        // Close the gap left by the entry at idx.
        function void drop(int unsigned idx);
            int unsigned i;
            for (i = idx; i + 1 < count; i++) begin
                slots[i] = slots[i + 1];
            end
            count--;
        endfunction

        // Apply one accepted item to the shadow table and queue its reports.
        function void note_action(action_item_t it);
            int unsigned      lim;
            int unsigned      p;
            int unsigned      i;
            logic             fail;
            logic [ID_W-1:0]  dispatched[$];
            task_entry_t      fresh;
            report_t          rep_item;
            lim = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
            fail = 1'b0;
            fresh = '{id: it.id, delay: it.delay, period: it.period, rep: it.rep, ready: 1'b0};
            case (it.act)
                ACT_APPEND: begin
                    if (count >= lim) begin
                        fail = 1'b1;
                    end else begin
                        slots[count] = fresh;
                        count++;
                    end
                end
                ACT_INSERT: begin
                    if (it.pos > lim || count >= lim) begin
                        fail = 1'b1;
                    end else begin
                        p = (it.pos > count) ? count : it.pos;
                        for (i = count; i > p; i--) begin
                            slots[i] = slots[i - 1];
                        end
                        slots[p] = fresh;
                        count++;
                    end
                end
                ACT_DELETE: begin
                    if (it.pos == 0 || it.pos > lim || it.pos > count) begin
                        fail = 1'b1;
                    end else begin
                        drop(it.pos - 1);
                    end
                end
                ACT_POP: begin
                    if (count == 0) begin
                        fail = 1'b1;
                    end else begin
                        count--;
                    end
                end
                ACT_TICK: begin
                    for (i = 0; i < count; i++) begin
                        if (slots[i].delay == 0) begin
                            slots[i].ready = 1'b1;
                            if (slots[i].rep) begin
                                slots[i].delay = slots[i].period;
                            end
                        end else begin
                            slots[i].delay = slots[i].delay - 1'b1;
                        end
                    end
                end
                ACT_DISPATCH: begin
                    i = 0;
                    while (i < count) begin
                        if (slots[i].ready) begin
                            dispatched.push_back(slots[i].id);
                            slots[i].ready = 1'b0;
                            if (!slots[i].rep) begin
                                drop(i);
                                continue;
                            end
                        end
                        i++;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
            // Run notices carry the occupancy after the whole action.
            foreach (dispatched[k]) begin
                rep_item = '{kind: KIND_RUN, run_id: dispatched[k], status: STATUS_OK,
                             occupancy: count[OCC_W-1:0], last: 1'b0};
                due_reports.push_back(rep_item);
            end
            rep_item = '{kind: KIND_STATUS, run_id: '0,
                         status: fail ? STATUS_FAIL : STATUS_OK,
                         occupancy: count[OCC_W-1:0], last: 1'b1};
            due_reports.push_back(rep_item);
        endfunction

        function void field_mismatch(string field, int unsigned want, int unsigned seen);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            errors++;
        endfunction

        // Compare one accepted result item with the oldest expected report.
        function void check_result(report_t got);
            report_t want;
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            if (got.kind !== want.kind) field_mismatch("kind", want.kind, got.kind);
            if (got.run_id !== want.run_id) field_mismatch("run_id", want.run_id, got.run_id);
            if (got.status !== want.status) field_mismatch("status", want.status, got.status);
            if (got.occupancy !== want.occupancy)
                field_mismatch("occupancy", want.occupancy, got.occupancy);
            if (got.last !== want.last) field_mismatch("last", want.last, got.last);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;

    sched_scoreboard sb;
    int unsigned     results_seen;
    int unsigned     rx_seen;
    int unsigned     rx_wait;
    bit              tx_burst;
    bit              rx_burst;

    tick_task_scheduler_table_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // Result monitor: sample on the rising edge and check every accepted item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result('{kind: m_tuser, run_id: m_tdata[OUT_ID_LSB +: ID_W],
                              status: m_tdata[OUT_ST_LSB],
                              occupancy: m_tdata[OUT_OCC_LSB +: OCC_W], last: m_tlast});
            results_seen++;
        end
    end

    // Result backpressure: after each accepted item, hold tready low for a random stall, none during bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (results_seen != rx_seen) begin
                rx_seen = results_seen;
                if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic action_item_t make_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                               logic [ID_W-1:0] id,
                                               logic [IN_DELAY_W-1:0] delay,
                                               logic [IN_DELAY_W-1:0] period, logic rep);
        return '{rep: rep, period: period, delay: delay, id: id, pos: pos, act: act};
    endfunction

    // Random action, weighted toward keeping tasks flowing through tick and dispatch.
    function automatic action_item_t random_item();
        action_item_t it;
        int unsigned  pick;
        int unsigned  held;
        pick = $urandom_range(0, 99);
        held = sb.task_count();
        it.id = ID_W'($urandom_range(0, 255));
        it.rep = 1'($urandom_range(0, 1));
        it.delay = IN_DELAY_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 3));
        it.period = IN_DELAY_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 4));
        it.pos = POS_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 16));
        if (pick < 22) begin
            it.act = ACT_APPEND;
        end else if (pick < 37) begin
            it.act = ACT_INSERT;
        end else if (pick < 48) begin
            it.act = ACT_DELETE;
            if (held > 0 && $urandom_range(0, 9) < 7) it.pos = POS_W'($urandom_range(1, held));
        end else if (pick < 53) begin
            it.act = ACT_POP;
        end else if (pick < 77) begin
            it.act = ACT_TICK;
        end else if (pick < 97) begin
            it.act = ACT_DISPATCH;
        end else begin
            it.act = $urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
        end
        return it;
    endfunction

    // Offer one item after a random gap and return at the edge that accepts it.
    task automatic send_item(action_item_t it);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= S_TDATA_W'({it.rep, it.period, it.delay, it.id, it.pos, it.act});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_action(it);
    endtask

    // Stop offering items and wait until every expected report has arrived.
    task automatic drain(int unsigned settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Write the table limit while the block is idle.
    task automatic set_table_limit(logic [LIMIT_W-1:0] value);
        drain(4);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_limit(value);
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limits[8];
        phase_limits = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0, 5'd9, 5'd16, 5'd2};
        sb = new;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        tx_burst = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset limit: extreme fields and every action.
        send_item(make_item(ACT_APPEND, 5'd0, 8'h00, 16'h0000, 16'h0000, 1'b0));
        send_item(make_item(ACT_APPEND, 5'd31, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(make_item(ACT_INSERT, 5'd0, 8'hA5, 16'd1, 16'd2, 1'b1));
        // Insert past the task count lands at the end.
        send_item(make_item(ACT_INSERT, 5'd16, 8'h5A, 16'd0, 16'd0, 1'b0));
        // Insert past the limit and bad delete positions all fail.
        send_item(make_item(ACT_INSERT, 5'd17, 8'h11, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DELETE, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DELETE, 5'd17, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DELETE, 5'd10, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_TICK, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DISPATCH, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_TICK, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_TICK, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DISPATCH, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DELETE, 5'd2, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_UNUSED_LO, 5'd1, 8'h01, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_UNUSED_HI, 5'd1, 8'h01, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_APPEND, 5'd0, 8'h3C, 16'd0, 16'd0, 1'b1));

        // Lowering the limit below the held tasks keeps them but blocks adds.
        set_table_limit(5'd1);
        send_item(make_item(ACT_APPEND, 5'd0, 8'h77, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_INSERT, 5'd0, 8'h78, 16'd0, 16'd0, 1'b0));
        // A zero limit makes the table always full.
        set_table_limit(5'd0);
        send_item(make_item(ACT_APPEND, 5'd0, 8'h79, 16'd0, 16'd0, 1'b0));
        set_table_limit(5'd16);
        repeat (4) send_item(make_item(ACT_POP, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        // Pop, tick and dispatch on an empty table.
        send_item(make_item(ACT_POP, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_TICK, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));
        send_item(make_item(ACT_DISPATCH, 5'd0, 8'h00, 16'd0, 16'd0, 1'b0));

        // Random part, one phase per limit setting.
        foreach (phase_limits[ph]) begin
            set_table_limit(phase_limits[ph]);
            repeat (62) send_item(random_item());
        end

        drain(40);
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("tb failed");
        $finish;
    end

endmodule
